// ===== src/tks_pkg.sv =====
`timescale 1ns / 1ps

package tks_pkg;

    // Width of one logit, fixed by the data format of the logit stream
    localparam int SCORE_W = 8;

    typedef logic signed [SCORE_W-1:0] t_score;

endpackage

// ===== src/tks_if.sv =====
`timescale 1ns / 1ps

// Logit stream: one class score per beat
interface tks_in_if
    import tks_pkg::*;
();
    logic   valid;
    logic   ready;
    t_score logit;
    logic   last_class;

    modport source (output valid, output logit, output last_class, input ready);
    modport sink   (input valid, input logit, input last_class, output ready);
endinterface

// Result stream: one kept entry per beat, best first
interface tks_out_if
    import tks_pkg::*;
#(
    parameter int RANK_W = 3,
    parameter int IDX_W  = 10
) ();
    logic              valid;
    logic              ready;
    logic [RANK_W-1:0] rank;
    logic [IDX_W-1:0]  class_index;
    t_score            score;
    logic              last_rank;

    modport source (output valid, output rank, output class_index, output score,
                    output last_rank, input ready);
    modport sink   (input valid, input rank, input class_index, input score,
                    input last_rank, output ready);
endinterface

// ===== src/tks_front.sv =====
`timescale 1ns / 1ps

// Insertion sorter: keeps the K best logits in descending order, one beat
// per cycle if the queue is ready; the last beat hands the list to the queue.
module tks_front
    import tks_pkg::*;
#(
    parameter int K      = 5,
    parameter int IDX_W  = 10,
    parameter int CNT_W  = 3,
    parameter int MAX_IX = 1023
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tks_in_if.sink           i_item,
    input  logic             i_q_ready,
    output logic             o_push,
    output t_score           o_scores [K],
    output logic [IDX_W-1:0] o_indices [K],
    output logic [CNT_W-1:0] o_count
);

    t_score             r_score [K];
    logic [IDX_W-1:0]   r_index [K];
    logic [CNT_W-1:0]   r_cnt;
    logic [IDX_W-1:0]   r_idx;

    t_score             n_score [K];
    logic [IDX_W-1:0]   n_index [K];
    logic [CNT_W-1:0]   n_cnt;
    logic [K-1:0]       keep;
    logic               accept;

    assign i_item.ready = i_q_ready;
    assign accept       = i_item.valid && i_q_ready;

    // An entry stays put when it is valid and not beaten; ties keep the old entry
    always_comb begin
        for (int i = 0; i < K; i++) begin
            keep[i] = (CNT_W'(i) < r_cnt) && (r_score[i] >= i_item.logit);
        end
    end

    // Entries below the insertion point shift down one slot
    always_comb begin
        for (int i = 0; i < K; i++) begin
            if (keep[i]) begin
                n_score[i] = r_score[i];
                n_index[i] = r_index[i];
            end else if (i == 0) begin
                n_score[i] = i_item.logit;
                n_index[i] = r_idx;
            end else if (keep[i-1]) begin
                n_score[i] = i_item.logit;
                n_index[i] = r_idx;
            end else begin
                n_score[i] = r_score[i-1];
                n_index[i] = r_index[i-1];
            end
        end
        n_cnt = (r_cnt < CNT_W'(K)) ? r_cnt + CNT_W'(1) : r_cnt;
    end

    // Sorted list payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_score <= n_score;
            r_index <= n_index;
        end
    end

    // Fill count and class counter, cleared after the last beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (accept) begin
            if (i_item.last_class) begin
                r_cnt <= '0;
                r_idx <= '0;
            end else begin
                r_cnt <= n_cnt;
                if (r_idx != IDX_W'(MAX_IX)) begin
                    r_idx <= r_idx + IDX_W'(1);
                end
            end
        end
    end

    assign o_push    = accept && i_item.last_class;
    assign o_scores  = n_score;
    assign o_indices = n_index;
    assign o_count   = n_cnt;

endmodule

// ===== src/tks_queue.sv =====
`timescale 1ns / 1ps

// Two-deep queue of finished sorted lists between sorter and emitter
module tks_queue
    import tks_pkg::*;
#(
    parameter int K     = 5,
    parameter int IDX_W = 10,
    parameter int CNT_W = 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  t_score           i_scores [K],
    input  logic [IDX_W-1:0] i_indices [K],
    input  logic [CNT_W-1:0] i_count,
    output logic             o_ready,
    input  logic             i_pop,
    output logic             o_valid,
    output t_score           o_scores [K],
    output logic [IDX_W-1:0] o_indices [K],
    output logic [CNT_W-1:0] o_count
);

    t_score           r_mem_s [2][K];
    logic [IDX_W-1:0] r_mem_i [2][K];
    logic [CNT_W-1:0] r_mem_c [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_fill;

    assign o_ready = (r_fill != 2'd2);
    assign o_valid = (r_fill != 2'd0);

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem_s[r_wp] <= i_scores;
            r_mem_i[r_wp] <= i_indices;
            r_mem_c[r_wp] <= i_count;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 2'd1;
            end else if (!i_push && i_pop) begin
                r_fill <= r_fill - 2'd1;
            end
        end
    end

    assign o_scores  = r_mem_s[r_rp];
    assign o_indices = r_mem_i[r_rp];
    assign o_count   = r_mem_c[r_rp];

endmodule

// ===== src/tks_back.sv =====
`timescale 1ns / 1ps

// Emitter: walks the head list best first into a registered output beat
module tks_back
    import tks_pkg::*;
#(
    parameter int K      = 5,
    parameter int IDX_W  = 10,
    parameter int CNT_W  = 3,
    parameter int RANK_W = 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_score           i_scores [K],
    input  logic [IDX_W-1:0] i_indices [K],
    input  logic [CNT_W-1:0] i_count,
    output logic             o_pop,
    tks_out_if.source        o_res
);

    logic [RANK_W-1:0] r_rank;
    logic              r_ovalid;
    logic [RANK_W-1:0] r_orank;
    logic [IDX_W-1:0]  r_oidx;
    t_score            r_oscore;
    logic              r_olast;

    logic              load;
    logic              at_end;

    assign load   = i_valid && (!r_ovalid || o_res.ready);
    assign at_end = (CNT_W'(r_rank) + CNT_W'(1)) == i_count;
    assign o_pop  = load && at_end;

    // Rank walker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (load) begin
                r_rank   <= at_end ? '0 : r_rank + RANK_W'(1);
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Output beat payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_orank  <= r_rank;
            r_oidx   <= i_indices[r_rank];
            r_oscore <= i_scores[r_rank];
            r_olast  <= at_end;
        end
    end

    assign o_res.valid       = r_ovalid;
    assign o_res.rank        = r_orank;
    assign o_res.class_index = r_oidx;
    assign o_res.score       = r_oscore;
    assign o_res.last_rank   = r_olast;

endmodule

// ===== src/top_k_logit_selector.sv =====
`timescale 1ns / 1ps
// Top-K logit selector: keeps the K largest logits of a vector, best first.
// Throughput: one logit per cycle while the queue has room, one result beat per
// cycle while the output is ready. Results pass the queue and an output register.
// A vector yields min(n, K) beats. Input stalls only while two sorted lists wait.
// Reset (synchronous, active low) clears counters, queue and output valid.
module top_k_logit_selector
    import tks_pkg::*;
#(
    parameter int K           = 5,
    parameter int MAX_CLASSES = 1024
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    tks_in_if.sink  i_item,
    tks_out_if.source o_res
);

    localparam int IDX_W  = $clog2(MAX_CLASSES);
    localparam int CNT_W  = $clog2(K + 1);
    localparam int RANK_W = (K > 1) ? $clog2(K) : 1;
    localparam int MAX_IX = MAX_CLASSES - 1;

    logic             push;
    logic             q_ready;
    logic             q_valid;
    logic             pop;
    t_score           f_scores [K];
    logic [IDX_W-1:0] f_indices [K];
    logic [CNT_W-1:0] f_count;
    t_score           h_scores [K];
    logic [IDX_W-1:0] h_indices [K];
    logic [CNT_W-1:0] h_count;

    tks_front #(
        .K(K), .IDX_W(IDX_W), .CNT_W(CNT_W), .MAX_IX(MAX_IX)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_scores  (f_scores),
        .o_indices (f_indices),
        .o_count   (f_count)
    );

    tks_queue #(
        .K(K), .IDX_W(IDX_W), .CNT_W(CNT_W)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_scores  (f_scores),
        .i_indices (f_indices),
        .i_count   (f_count),
        .o_ready   (q_ready),
        .i_pop     (pop),
        .o_valid   (q_valid),
        .o_scores  (h_scores),
        .o_indices (h_indices),
        .o_count   (h_count)
    );

    tks_back #(
        .K(K), .IDX_W(IDX_W), .CNT_W(CNT_W), .RANK_W(RANK_W)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (q_valid),
        .i_scores  (h_scores),
        .i_indices (h_indices),
        .i_count   (h_count),
        .o_pop     (pop),
        .o_res     (o_res)
    );

endmodule
